>>> rtl/hcs_pkg.sv
// Shared types, constants and mod 26 helpers for the streaming 2x2 Hill cipher.
// No dependencies. Used by hcs_ctrl, hcs_datapath and hill_cipher_2x2_stream.
package hcs_pkg;

	localparam int unsigned LETTER_W   = 5;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned PIPE_DEPTH = 6;
	localparam int unsigned CNT_W      = 3;

	localparam logic [LETTER_W-1:0] ALPHA      = 5'd26 - 5'd0;
	localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd23;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_00  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_01  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_10  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_11  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT = 3'd4;

	typedef struct packed {
		logic [LETTER_W-1:0] letter_in;
		logic                message_end;
	} in_t;

	typedef struct packed {
		logic [LETTER_W-1:0] letter_out;
		logic                run_last;
		logic                key_error;
	} out_t;

	typedef struct packed {
		logic capture;
		logic pad;
		logic hold;
		logic out_sel;
	} ctrl_cmd_t;

	typedef struct packed {
		logic decrypt_mode;
	} dp_status_t;

	// Brings a 5-bit value into 0..25.
	function automatic logic [LETTER_W-1:0] red26(input logic [LETTER_W-1:0] v);
		return (v >= 5'd26) ? v - 5'd26 : v;
	endfunction

	// Remainder mod 26 of an 11-bit value: the reciprocal estimate never
	// overshoots the quotient and is at most one short, so one correction fixes it.
	function automatic logic [LETTER_W-1:0] mod26(input logic [10:0] x);
		logic [19:0] prod;
		logic [6:0]  q;
		logic [10:0] r;
		prod = 20'(x) * 20'd315;
		q    = prod[19:13];
		r    = x - 11'(q) * 11'd26;
		if (r >= 11'd26) begin
			r = r - 11'd26;
		end
		return r[4:0];
	endfunction

	// Multiplicative inverse mod 26; zero where none exists.
	function automatic logic [LETTER_W-1:0] inv26(input logic [LETTER_W-1:0] d);
		logic [LETTER_W-1:0] r;
		case (d)
			5'd1:    r = 5'd1;
			5'd3:    r = 5'd9;
			5'd5:    r = 5'd21;
			5'd7:    r = 5'd15;
			5'd9:    r = 5'd3;
			5'd11:   r = 5'd19;
			5'd15:   r = 5'd7;
			5'd17:   r = 5'd23;
			5'd19:   r = 5'd11;
			5'd21:   r = 5'd5;
			5'd23:   r = 5'd17;
			5'd25:   r = 5'd25;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/hill_cipher_2x2_stream.sv
// Top level of the streaming 2x2 Hill cipher over the letters a..z (0..25).
// Depends on hcs_pkg, hcs_ctrl and hcs_datapath.

// Letters arrive one beat at a time on the input channel. The first letter of
// each pair is held; the second completes the pair, which is multiplied as a
// row vector by the 2x2 key mod 26 and leaves as two output beats, the second
// marked by run_last. In decrypt mode the key is replaced by its inverse mod 26
// (inverse of the determinant times the adjugate); if the determinant has no
// inverse both beats still leave, with letter_out 0 and key_error set. A message
// ending on an odd letter is padded with x when encrypting, and the odd letter is
// dropped when decrypting. Letters and key entries of 26 to 31 are reduced mod 26.
// Timing: a letter that only opens a pair, or an odd letter that is dropped, is
// taken without leaving the idle state. A completed pair passes through the
// six-stage datapath (determinant products, determinant reduction, inverse
// lookup and adjugate products, reduction, vector products, final reduction)
// and then leaves as the two output beats; no new letter is taken
// until the second output beat has gone. Configuration writes take effect at
// once and are meant to be made while the block is idle.
module hill_cipher_2x2_stream (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  hcs_pkg::in_t                      in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output hcs_pkg::out_t                     out_data,
	input  logic                              cfg_we,
	input  logic [hcs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hcs_pkg::LETTER_W-1:0]      cfg_data
);

	hcs_pkg::ctrl_cmd_t  cmd;
	hcs_pkg::dp_status_t status;

	// The controller decides pairing, padding and dropping, and sequences the beats.
	hcs_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.message_end (in_data.message_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.cmd         (cmd)
	);

	// The datapath holds the key registers and does all the mod 26 arithmetic.
	hcs_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.letter_in (in_data.letter_in),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	// Only one pair is in flight: input is never offered while a result waits.
	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && in_ready))
		else $error("input ready while a result beat is pending");

	// The first beat of a pair is always followed by its second.
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !out_data.run_last) |=> (out_valid && out_data.run_last))
		else $error("first beat of a pair not followed by the second");

	// A singular key is only reported in decrypt mode and always gives letter 0.
	a_key_error: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.key_error) |-> (status.decrypt_mode && out_data.letter_out == '0))
		else $error("key error outside decrypt mode or with a non-zero letter");

	// Results stay in range.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.letter_out < 5'd26))
		else $error("output letter out of range");
`endif

endmodule

>>> rtl/hcs_ctrl.sv
// Controller for the streaming 2x2 Hill cipher: pairing, pipeline wait, output beats.
// Depends on hcs_pkg.
module hcs_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   message_end,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  hcs_pkg::dp_status_t    status,
	output hcs_pkg::ctrl_cmd_t     cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BUSY = 2'd1;
	localparam logic [1:0] ST_OUT0 = 2'd2;
	localparam logic [1:0] ST_OUT1 = 2'd3;

	logic [1:0]                  state_q;
	logic [hcs_pkg::CNT_W-1:0]   cnt_q;
	logic                        half_q;
	logic                        in_fire;
	logic                        start_pair;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = (state_q == ST_OUT0) || (state_q == ST_OUT1);

	// A pair starts when it completes, or on an odd final letter in encrypt mode.
	assign start_pair = in_fire && (half_q || (message_end && !status.decrypt_mode));

	always_comb begin
		cmd.capture = start_pair;
		cmd.pad     = !half_q;
		cmd.hold    = in_fire && !half_q && !message_end;
		cmd.out_sel = (state_q == ST_OUT1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			half_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						half_q <= !half_q && !message_end;
					end
					if (start_pair) begin
						state_q <= ST_BUSY;
						cnt_q   <= '0;
					end
				end
				ST_BUSY: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == hcs_pkg::CNT_W'(hcs_pkg::PIPE_DEPTH - 1)) begin
						state_q <= ST_OUT0;
					end
				end
				ST_OUT0: begin
					if (out_ready) begin
						state_q <= ST_OUT1;
					end
				end
				ST_OUT1: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/hcs_datapath.sv
// Datapath for the streaming 2x2 Hill cipher: key registers, held letter,
// six-stage working-key and vector-product pipeline. Depends on hcs_pkg.
module hcs_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [hcs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hcs_pkg::LETTER_W-1:0]       cfg_data,
	input  logic [hcs_pkg::LETTER_W-1:0]       letter_in,
	input  hcs_pkg::ctrl_cmd_t                 cmd,
	output hcs_pkg::dp_status_t                status,
	output hcs_pkg::out_t                      out_data
);

	localparam int unsigned LW = hcs_pkg::LETTER_W;

	logic [LW-1:0] key00_q, key01_q, key10_q, key11_q;
	logic          decrypt_q;
	logic [LW-1:0] held_q;

	logic [LW-1:0] p0_q, p1_q, ka_q, kb_q, kc_q, kd_q;
	logic          mode_q;

	logic [9:0]    ad_s1, bc_s1;
	logic [LW-1:0] det_s2;
	logic [9:0]    m00_s3, m01_s3, m10_s3, m11_s3;
	logic          ok_s3;
	logic [LW-1:0] w00_s4, w01_s4, w10_s4, w11_s4;
	logic          ok_s4;
	logic [9:0]    t0a_s5, t0b_s5, t1a_s5, t1b_s5;
	logic          ok_s5;
	logic [LW-1:0] r0_s6, r1_s6;
	logic          ok_s6;

	logic [LW-1:0] inv_det, neg_b, neg_c;

	assign status.decrypt_mode = decrypt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key00_q   <= 5'd1;
			key01_q   <= 5'd0;
			key10_q   <= 5'd0;
			key11_q   <= 5'd1;
			decrypt_q <= 1'b0;
			held_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					hcs_pkg::CFG_KEY_00:  key00_q   <= cfg_data;
					hcs_pkg::CFG_KEY_01:  key01_q   <= cfg_data;
					hcs_pkg::CFG_KEY_10:  key10_q   <= cfg_data;
					hcs_pkg::CFG_KEY_11:  key11_q   <= cfg_data;
					hcs_pkg::CFG_DECRYPT: decrypt_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.hold) begin
				held_q <= letter_in;
			end
		end
	end

	// Operand capture for a pair; the key in force at that point is used.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			p0_q   <= hcs_pkg::red26(cmd.pad ? letter_in : held_q);
			p1_q   <= cmd.pad ? hcs_pkg::PAD_LETTER : hcs_pkg::red26(letter_in);
			ka_q   <= hcs_pkg::red26(key00_q);
			kb_q   <= hcs_pkg::red26(key01_q);
			kc_q   <= hcs_pkg::red26(key10_q);
			kd_q   <= hcs_pkg::red26(key11_q);
			mode_q <= decrypt_q;
		end
	end

	assign inv_det = hcs_pkg::inv26(det_s2);
	assign neg_b   = (kb_q == '0) ? '0 : hcs_pkg::ALPHA - kb_q;
	assign neg_c   = (kc_q == '0) ? '0 : hcs_pkg::ALPHA - kc_q;

	always_ff @(posedge clk) begin
		ad_s1  <= 10'(ka_q) * 10'(kd_q);
		bc_s1  <= 10'(kb_q) * 10'(kc_q);

		det_s2 <= hcs_pkg::mod26(11'(ad_s1) + 11'd676 - 11'(bc_s1));

		m00_s3 <= 10'(inv_det) * 10'(kd_q);
		m01_s3 <= 10'(inv_det) * 10'(neg_b);
		m10_s3 <= 10'(inv_det) * 10'(neg_c);
		m11_s3 <= 10'(inv_det) * 10'(ka_q);
		ok_s3  <= !mode_q || (inv_det != '0);

		w00_s4 <= mode_q ? hcs_pkg::mod26(11'(m00_s3)) : ka_q;
		w01_s4 <= mode_q ? hcs_pkg::mod26(11'(m01_s3)) : kb_q;
		w10_s4 <= mode_q ? hcs_pkg::mod26(11'(m10_s3)) : kc_q;
		w11_s4 <= mode_q ? hcs_pkg::mod26(11'(m11_s3)) : kd_q;
		ok_s4  <= ok_s3;

		t0a_s5 <= 10'(p0_q) * 10'(w00_s4);
		t0b_s5 <= 10'(p1_q) * 10'(w10_s4);
		t1a_s5 <= 10'(p0_q) * 10'(w01_s4);
		t1b_s5 <= 10'(p1_q) * 10'(w11_s4);
		ok_s5  <= ok_s4;

		r0_s6  <= hcs_pkg::mod26(11'(t0a_s5) + 11'(t0b_s5));
		r1_s6  <= hcs_pkg::mod26(11'(t1a_s5) + 11'(t1b_s5));
		ok_s6  <= ok_s5;
	end

	always_comb begin
		out_data.letter_out = ok_s6 ? (cmd.out_sel ? r1_s6 : r0_s6) : '0;
		out_data.run_last   = cmd.out_sel;
		out_data.key_error  = !ok_s6;
	end

endmodule
